[src/unix_time_to_calendar_core_assert.svh]
// Assertion macros for the calendar core.
`ifndef UNIX_TIME_TO_CALENDAR_CORE_ASSERT_SVH
`define UNIX_TIME_TO_CALENDAR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UTC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UTC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UTC_ASSERT(label, clk, rst_n, prop, msg)
`define UTC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[src/utc_pkg.sv]
package utc_pkg;

  localparam int TS_W    = 32;
  localparam int OFF_W   = 17;
  localparam int DAYS_W  = 15;
  localparam int TOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int YEAR_W  = 11;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int MINS_W  = 11;

  localparam int MONTHS = 12;
  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 11'd1970;

  typedef struct packed {
    logic              err;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } utc_split_t;

  typedef struct packed {
    logic              err;
    logic [YEAR_W-1:0] year;
    logic              leap;
    logic [DOY_W-1:0]  doy;
    logic [WDAY_W-1:0] weekday;
    logic [HOUR_W-1:0] hour;
    logic [MINS_W-1:0] mins;
    logic [SEC_W-1:0]  second;
  } utc_date_t;

  // First day of year of each month (0 based); leap years shift from March on.
  function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

[src/utc_day_split.sv]
module utc_day_split (
  input  logic signed [utc_pkg::TS_W-1:0]  ts_i,
  input  logic signed [utc_pkg::OFF_W-1:0] off_i,
  output utc_pkg::utc_split_t              split_o
);
  import utc_pkg::*;

  // 86400 = 128 * 675: shift off the low seven bits, then divide by 675
  localparam int SUM_W   = TS_W + 1;
  localparam int LOW_W   = 7;
  localparam int N_W     = TS_W - LOW_W;
  localparam int RCP_W   = 26;
  localparam int PROD_W  = N_W + RCP_W;
  localparam int SHIFT   = 35;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam int REM_W   = 10;
  localparam logic [RCP_W-1:0] RECIP  = 26'd50903316;
  localparam logic [REM_W-1:0] DIV_HI = 10'd675;

  logic signed [SUM_W-1:0] adj;
  logic [N_W-1:0]          n;
  logic [PROD_W-1:0]       prod;
  logic [Q_W-1:0]          q_est;
  logic [N_W-1:0]          rem_wide;
  logic [REM_W:0]          rem_est;
  logic [Q_W-1:0]          q;
  logic [REM_W-1:0]        rem;

  assign adj      = SUM_W'(ts_i) + SUM_W'(off_i);
  assign n        = adj[TS_W-1:LOW_W];
  assign prod     = PROD_W'(n) * PROD_W'(RECIP);
  assign q_est    = prod[PROD_W-1:SHIFT];
  // estimate is exact or one low
  assign rem_wide = n - N_W'(N_W'(q_est) * N_W'(DIV_HI));
  assign rem_est  = rem_wide[REM_W:0];

  always_comb begin
    if (rem_est >= (REM_W+1)'(DIV_HI)) begin
      q   = q_est + Q_W'(1);
      rem = REM_W'(rem_est - (REM_W+1)'(DIV_HI));
    end else begin
      q   = q_est;
      rem = rem_est[REM_W-1:0];
    end
  end

  assign split_o.err  = ts_i[TS_W-1] | adj[SUM_W-1];
  assign split_o.days = q[DAYS_W-1:0];
  assign split_o.tod  = {rem, adj[LOW_W-1:0]};

endmodule

[src/utc_month_find.sv]
module utc_month_find (
  input  utc_pkg::utc_date_t                date_i,
  output logic [utc_pkg::MONTH_W-1:0]       month_o,
  output logic [utc_pkg::DAY_W-1:0]         day_o
);
  import utc_pkg::*;

  logic [MONTH_W-1:0] idx;
  logic [DOY_W-1:0]   off;

  // last month whose first day is not after the day of year
  always_comb begin
    idx = '0;
    for (int i = 1; i < MONTHS; i++) begin
      if (date_i.doy >= month_start(date_i.leap, MONTH_W'(i))) begin
        idx = MONTH_W'(i);
      end
    end
  end

  assign off     = date_i.doy - month_start(date_i.leap, idx);
  assign month_o = idx + MONTH_W'(1);
  assign day_o   = DAY_W'(off + DOY_W'(1));

endmodule

[src/unix_time_to_calendar_core.sv]
// Channel  Signals                                 Direction
// in       in_valid / in_ready, in_unix_seconds    request in
// out      out_valid / out_ready, out_error ...    result out
// cfg      cfg_wr_en, cfg_wr_data                  zone offset write
//
// Four register stages: input, day split, date parts, result.
// One request per cycle while out_ready keeps up; results leave in order.
// Each stage holds only while the one after it is full and stalled, so
// bubbles close up and input is taken while a result waits.
// Synchronous active-low reset clears the stage valids and the zone offset.
`include "unix_time_to_calendar_core_assert.svh"
module unix_time_to_calendar_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [utc_pkg::TS_W-1:0]   in_unix_seconds,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_error,
  output logic [utc_pkg::YEAR_W-1:0]        out_year,
  output logic [utc_pkg::MONTH_W-1:0]       out_month,
  output logic [utc_pkg::DAY_W-1:0]         out_day,
  output logic [utc_pkg::WDAY_W-1:0]        out_weekday,
  output logic                              out_leap,
  output logic [utc_pkg::HOUR_W-1:0]        out_hour,
  output logic [utc_pkg::MIN_W-1:0]         out_minute,
  output logic [utc_pkg::SEC_W-1:0]         out_second,
  input  logic                              cfg_wr_en,
  input  logic signed [utc_pkg::OFF_W-1:0]  cfg_wr_data
);
  import utc_pkg::*;

  // days / 1461 (four-year cycle)
  localparam int CYC_W      = 5;
  localparam int CYC_PROD_W = 30;
  localparam int CYC_SHIFT  = 25;
  localparam int CREM_W     = 12;
  localparam logic [DAYS_W-1:0] CYC_RECIP = 15'd22966;
  localparam logic [CREM_W-1:0] CYC_DAYS  = 12'd1461;
  // (days + 4) mod 7
  localparam int W_W        = DAYS_W + 1;
  localparam int W_PROD_W   = 33;
  localparam int W_SHIFT    = 19;
  localparam int WQ_W       = W_PROD_W - W_SHIFT;
  localparam int WREM_W     = 4;
  localparam logic [16:0]       W_RECIP = 17'd74898;
  localparam logic [WREM_W-1:0] W_DIV   = 4'd7;
  // tod / 3600 and tod / 60
  localparam int T_PROD_W   = 35;
  localparam int H_SHIFT    = 29;
  localparam int HQ_W       = T_PROD_W - H_SHIFT;
  localparam int HREM_W     = 13;
  localparam int M_SHIFT    = 23;
  localparam int MREM_W     = 7;
  localparam logic [17:0]       H_RECIP = 18'd149130;
  localparam logic [17:0]       M_RECIP = 18'd139810;
  localparam logic [HREM_W-1:0] SECS_HR = 13'd3600;
  localparam logic [MREM_W-1:0] SECS_MN = 7'd60;

  logic signed [OFF_W-1:0] zone_r;

  logic                    a_v_r, b_v_r, c_v_r, out_v_r;
  logic                    a_rdy, b_rdy, c_rdy, o_rdy;
  logic signed [TS_W-1:0]  a_ts_r;
  utc_split_t              b_nxt, b_r;
  utc_date_t               c_nxt, c_r;

  logic [CYC_PROD_W-1:0] cyc_prod;
  logic [CYC_W-1:0]      cyc_est, cyc;
  logic [CREM_W-1:0]     cyc_rem_est;
  logic [CREM_W-2:0]     cyc_rem;
  logic [1:0]            yr_in_cyc;

  logic [W_W-1:0]        w;
  logic [W_PROD_W-1:0]   w_prod;
  logic [WQ_W-1:0]       w_q;
  logic [WREM_W-1:0]     w_rem;

  logic [T_PROD_W-1:0]   h_prod, m_prod;
  logic [HQ_W-1:0]       h_est;
  logic [HREM_W-1:0]     h_rem;
  logic [MINS_W-1:0]     m_est;
  logic [MREM_W-1:0]     m_rem;

  logic [MONTH_W-1:0]    d_month;
  logic [DAY_W-1:0]      d_day;
  logic [MIN_W-1:0]      d_minute;

  logic                  out_error_r, out_leap_r;
  logic [YEAR_W-1:0]     out_year_r;
  logic [MONTH_W-1:0]    out_month_r;
  logic [DAY_W-1:0]      out_day_r;
  logic [WDAY_W-1:0]     out_weekday_r;
  logic [HOUR_W-1:0]     out_hour_r;
  logic [MIN_W-1:0]      out_minute_r;
  logic [SEC_W-1:0]      out_second_r;

  // stage ready chain
  assign o_rdy    = !out_v_r || out_ready;
  assign c_rdy    = !c_v_r || o_rdy;
  assign b_rdy    = !b_v_r || c_rdy;
  assign a_rdy    = !a_v_r || b_rdy;
  assign in_ready = a_rdy;

  utc_day_split u_day_split (
    .ts_i    (a_ts_r),
    .off_i   (zone_r),
    .split_o (b_nxt)
  );

  // year within the four-year cycle; third year is the leap one
  assign cyc_prod    = CYC_PROD_W'(b_r.days) * CYC_PROD_W'(CYC_RECIP);
  assign cyc_est     = cyc_prod[CYC_SHIFT+CYC_W-1:CYC_SHIFT];
  assign cyc_rem_est = CREM_W'(b_r.days - DAYS_W'(DAYS_W'(cyc_est) * DAYS_W'(CYC_DAYS)));

  always_comb begin
    if (cyc_rem_est >= CYC_DAYS) begin
      cyc     = cyc_est + CYC_W'(1);
      cyc_rem = (CREM_W-1)'(cyc_rem_est - CYC_DAYS);
    end else begin
      cyc     = cyc_est;
      cyc_rem = cyc_rem_est[CREM_W-2:0];
    end
  end

  always_comb begin
    c_nxt.leap = 1'b0;
    if (cyc_rem < 11'd365) begin
      yr_in_cyc = 2'd0;
      c_nxt.doy = DOY_W'(cyc_rem);
    end else if (cyc_rem < 11'd730) begin
      yr_in_cyc = 2'd1;
      c_nxt.doy = DOY_W'(cyc_rem - 11'd365);
    end else if (cyc_rem < 11'd1096) begin
      yr_in_cyc  = 2'd2;
      c_nxt.doy  = DOY_W'(cyc_rem - 11'd730);
      c_nxt.leap = 1'b1;
    end else begin
      yr_in_cyc = 2'd3;
      c_nxt.doy = DOY_W'(cyc_rem - 11'd1096);
    end
  end

  assign c_nxt.err  = b_r.err;
  assign c_nxt.year = EPOCH_YEAR + YEAR_W'({cyc, 2'b00}) + YEAR_W'(yr_in_cyc);

  // day 0 was a Thursday
  assign w      = W_W'(b_r.days) + W_W'(4);
  assign w_prod = W_PROD_W'(w) * W_PROD_W'(W_RECIP);
  assign w_q    = w_prod[W_PROD_W-1:W_SHIFT];
  assign w_rem  = WREM_W'(w - W_W'(W_W'(w_q) * W_W'(W_DIV)));
  assign c_nxt.weekday = (w_rem >= W_DIV) ? WDAY_W'(w_rem - W_DIV) : WDAY_W'(w_rem);

  assign h_prod = T_PROD_W'(b_r.tod) * T_PROD_W'(H_RECIP);
  assign h_est  = h_prod[T_PROD_W-1:H_SHIFT];
  assign h_rem  = HREM_W'(b_r.tod - TOD_W'(TOD_W'(h_est) * TOD_W'(SECS_HR)));
  assign c_nxt.hour = (h_rem >= SECS_HR) ? HOUR_W'(h_est + HQ_W'(1)) : HOUR_W'(h_est);

  assign m_prod = T_PROD_W'(b_r.tod) * T_PROD_W'(M_RECIP);
  assign m_est  = m_prod[M_SHIFT+MINS_W-1:M_SHIFT];
  assign m_rem  = MREM_W'(b_r.tod - TOD_W'(TOD_W'(m_est) * TOD_W'(SECS_MN)));

  always_comb begin
    if (m_rem >= SECS_MN) begin
      c_nxt.mins   = m_est + MINS_W'(1);
      c_nxt.second = SEC_W'(m_rem - SECS_MN);
    end else begin
      c_nxt.mins   = m_est;
      c_nxt.second = SEC_W'(m_rem);
    end
  end

  utc_month_find u_month_find (
    .date_i  (c_r),
    .month_o (d_month),
    .day_o   (d_day)
  );

  assign d_minute = MIN_W'(c_r.mins - MINS_W'(MINS_W'(c_r.hour) * MINS_W'(SECS_MN)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r  <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        zone_r <= cfg_wr_data;
      end
      if (a_rdy) begin
        a_v_r <= in_valid;
      end
      if (b_rdy) begin
        b_v_r <= a_v_r;
      end
      if (c_rdy) begin
        c_v_r <= b_v_r;
      end
      if (o_rdy) begin
        out_v_r <= c_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_ts_r <= in_unix_seconds;
    end
    if (b_rdy && a_v_r) begin
      b_r <= b_nxt;
    end
    if (c_rdy && b_v_r) begin
      c_r <= c_nxt;
    end
    if (o_rdy && c_v_r) begin
      // a rejected request reports the flag and nothing else
      out_error_r   <= c_r.err;
      out_year_r    <= c_r.err ? '0 : c_r.year;
      out_month_r   <= c_r.err ? '0 : d_month;
      out_day_r     <= c_r.err ? '0 : d_day;
      out_weekday_r <= c_r.err ? '0 : c_r.weekday;
      out_leap_r    <= c_r.err ? 1'b0 : c_r.leap;
      out_hour_r    <= c_r.err ? '0 : c_r.hour;
      out_minute_r  <= c_r.err ? '0 : d_minute;
      out_second_r  <= c_r.err ? '0 : c_r.second;
    end
  end

  assign out_valid   = out_v_r;
  assign out_error   = out_error_r;
  assign out_year    = out_year_r;
  assign out_month   = out_month_r;
  assign out_day     = out_day_r;
  assign out_weekday = out_weekday_r;
  assign out_leap    = out_leap_r;
  assign out_hour    = out_hour_r;
  assign out_minute  = out_minute_r;
  assign out_second  = out_second_r;

  `UTC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid && in_ready,
    "reset left a request in flight")
  `UTC_ASSERT(a_stall_only_full, clk, rst_n,
    !in_ready |-> a_v_r && b_v_r && c_v_r && out_v_r && !out_ready,
    "input stalled with a free stage")
  `UTC_ASSERT(a_err_zeroes, clk, rst_n,
    out_valid && out_error |-> out_year == '0 && out_month == '0 && out_day == '0 &&
      out_hour == '0 && out_minute == '0 && out_second == '0 && !out_leap,
    "error result carries data")
  `UTC_ASSERT(a_fields_range, clk, rst_n,
    out_valid && !out_error |-> out_month != '0 && out_month <= 4'd12 && out_day != '0 &&
      out_weekday <= 3'd6 && out_hour <= 5'd23 && out_minute <= 6'd59 &&
      out_second <= 6'd59,
    "field out of range")
  `UTC_ASSERT(a_leap_year, clk, rst_n,
    out_valid && !out_error |-> out_leap == (out_year[1:0] == 2'b00),
    "leap flag disagrees with year")

endmodule

[bench/tb_unix_time_to_calendar_core.sv]
module tb_unix_time_to_calendar_core;
  import utc_pkg::*;

  typedef struct packed {
    logic               err;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  weekday;
    logic               leap;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } civil_t;

  typedef struct packed {
    logic [TS_W-1:0] stamp;
    civil_t          date;
  } pending_t;

  localparam int SECS_PER_DAY = 86400;
  localparam int CYCLE_DAYS   = 1461;
  localparam int REPORT_LIMIT = 10;
  localparam int HOLD_CYCLES  = 300;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TS_W-1:0]   in_unix_seconds = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_error;
  logic [YEAR_W-1:0]        out_year;
  logic [MONTH_W-1:0]       out_month;
  logic [DAY_W-1:0]         out_day;
  logic [WDAY_W-1:0]        out_weekday;
  logic                     out_leap;
  logic [HOUR_W-1:0]        out_hour;
  logic [MIN_W-1:0]         out_minute;
  logic [SEC_W-1:0]         out_second;
  logic                     cfg_wr_en = 1'b0;
  logic signed [OFF_W-1:0]  cfg_wr_data = '0;

  int month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic signed [OFF_W-1:0] zone_offset = '0;
  pending_t pending_dates [$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_off_req = 0;
  int rx_stall_left = 0;

  int n_sent = 0;
  int n_checked = 0;
  int n_rejected = 0;
  int n_zones = 0;
  int n_fail = 0;

  unix_time_to_calendar_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_unix_seconds (in_unix_seconds),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_error       (out_error),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_weekday     (out_weekday),
    .out_leap        (out_leap),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Civil date of local time; the sum is taken at full width, no wrap.
  function automatic civil_t civil_from_unix(input logic signed [TS_W-1:0] stamp,
                                             input logic signed [OFF_W-1:0] offset);
    civil_t c;
    longint local_secs;
    longint days;
    longint tod;
    longint doy;
    longint yr;
    int     m;
    int     mlen;
    logic   found;
    c = '0;
    local_secs = longint'(stamp) + longint'(offset);
    if (stamp < 0 || local_secs < 0) begin
      c.err = 1'b1;
      return c;
    end
    days = local_secs / SECS_PER_DAY;
    tod  = local_secs % SECS_PER_DAY;
    doy  = days % CYCLE_DAYS;
    yr   = 1970 + 4 * (days / CYCLE_DAYS);
    // leap year is the third of each four-year cycle
    if (doy >= 1096) begin
      yr += 3;
      doy -= 1096;
    end else if (doy >= 730) begin
      yr += 2;
      doy -= 730;
      c.leap = 1'b1;
    end else if (doy >= 365) begin
      yr += 1;
      doy -= 365;
    end
    c.year = YEAR_W'(yr);
    c.month = MONTH_W'(12);
    found = 1'b0;
    for (m = 0; m < 12; m++) begin
      mlen = month_len[m] + ((c.leap && m == 1) ? 1 : 0);
      if (!found) begin
        if (doy < mlen) begin
          c.month = MONTH_W'(m + 1);
          found = 1'b1;
        end else begin
          doy -= mlen;
        end
      end
    end
    c.day     = DAY_W'(doy + 1);
    c.weekday = WDAY_W'((days + 4) % 7);
    c.hour    = HOUR_W'(tod / 3600);
    c.minute  = MIN_W'((tod % 3600) / 60);
    c.second  = SEC_W'(tod % 60);
    return c;
  endfunction

  function automatic string civil_text(input civil_t c);
    return $sformatf("err=%0d %0d-%0d-%0d wd=%0d leap=%0d %0d:%0d:%0d", c.err, c.year,
                     c.month, c.day, c.weekday, c.leap, c.hour, c.minute, c.second);
  endfunction

  // mostly back to back, some short gaps, the odd long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [TS_W-1:0] random_stamp();
    logic [TS_W-1:0] raw;
    longint          d;
    longint          t;
    int              y;
    raw = $urandom;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4, 5: raw[TS_W-1] = 1'b0;
      6, 7: begin
        // around a year boundary somewhere in the span
        y = $urandom_range(0, 3);
        d = longint'($urandom_range(0, 16)) * CYCLE_DAYS + y * 365 + (y == 3 ? 1 : 0)
            - $urandom_range(0, 1);
        t = d * SECS_PER_DAY +
            ($urandom_range(0, 1) ? $urandom_range(0, 86399) : 86399 * $urandom_range(0, 1));
        raw = t[TS_W-1:0];
        raw[TS_W-1] = 1'b0;
      end
      8: raw = $urandom_range(0, 200000);
      default: raw = 32'h7FFF_FFFF - $urandom_range(0, 200000);
    endcase
    return raw;
  endfunction

  task automatic send_stamp(input logic signed [TS_W-1:0] stamp);
    int gap;
    in_valid        <= 1'b1;
    in_unix_seconds <= stamp;
    do @(posedge clk); while (!in_ready);
    pending_dates.push_back({stamp, civil_from_unix(stamp, zone_offset)});
    n_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_dates.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_zone(input int value);
    wait_for_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= OFF_W'(value);
    zone_offset = OFF_W'(value);
    n_zones++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Reset offset; epoch, cycle and leap-day edges, sign extremes.
  task automatic test_directed_epoch();
    send_stamp(0);
    send_stamp(1);
    send_stamp(SECS_PER_DAY - 1);
    send_stamp(SECS_PER_DAY);
    send_stamp(365 * SECS_PER_DAY - 1);
    send_stamp(365 * SECS_PER_DAY);
    send_stamp(789 * SECS_PER_DAY);
    send_stamp(1095 * SECS_PER_DAY + 86399);
    send_stamp(1096 * SECS_PER_DAY);
    send_stamp(CYCLE_DAYS * SECS_PER_DAY - 1);
    send_stamp(CYCLE_DAYS * SECS_PER_DAY);
    send_stamp(11016 * SECS_PER_DAY);
    send_stamp(11322 * SECS_PER_DAY + 43200);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h5555_5555);
    send_stamp(-1);
    send_stamp(32'h8000_0000);
    send_stamp(32'hAAAA_AAAA);
  endtask

  // Offset extremes: adjusted time just below and at zero, and the top of 2038.
  task automatic test_offset_extremes();
    set_zone(-65536);
    send_stamp(65535);
    send_stamp(65536);
    send_stamp(32'h7FFF_FFFF);
    set_zone(65535);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(-1);
    send_stamp(0);
    set_zone(50400);
    send_stamp(0);
    set_zone(-50400);
    send_stamp(50399);
    send_stamp(50400);
  endtask

  task automatic test_random_zones();
    int zones [7];
    int p;
    int i;
    zones = '{0, int'($urandom_range(0, 100800)) - 50400, -65536, 65535, -18000, 19800,
              int'($urandom_range(0, 131071)) - 65536};
    for (p = 0; p < 7; p++) begin
      set_zone(zones[p]);
      // first phase runs flat out on both sides, the fourth only on the request side
      tx_steady = (p == 0 || p == 3);
      rx_steady = (p == 0);
      for (i = 0; i < 165; i++) send_stamp(random_stamp());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side stalls long enough for the pipeline to fill and stop taking requests.
  task automatic test_output_backpressure();
    int i;
    wait_for_idle();
    tx_steady = 1'b1;
    hold_off_req = HOLD_CYCLES;
    for (i = 0; i < 40; i++) send_stamp(random_stamp());
    tx_steady = 1'b0;
  endtask

  initial begin : sink
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        rx_stall_left = hold_off_req;
        hold_off_req = 0;
      end
      if (rx_stall_left > 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_stall_left = gap - 1;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    civil_t   got;
    pending_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_error, out_year, out_month, out_day, out_weekday, out_leap,
             out_hour, out_minute, out_second};
      if (pending_dates.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_LIMIT)
          $display("unexpected result: %s", civil_text(got));
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if (want.date.err) n_rejected++;
        if (got !== want.date) begin
          n_fail++;
          if (n_fail <= REPORT_LIMIT) begin
            $display("mismatch for stamp %0d, offset %0d", $signed(want.stamp), zone_offset);
            $display("  expected %s", civil_text(want.date));
            $display("  actual   %s", civil_text(got));
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_epoch();
    test_offset_extremes();
    test_random_zones();
    test_output_backpressure();
    wait_for_idle();
    repeat (10) @(posedge clk);
    $display("%0d requests sent, %0d results checked across %0d zone offsets",
             n_sent, n_checked, n_zones);
    $display("%0d of them rejected as negative; %0d failures", n_rejected, n_fail);
    if (n_fail == 0) begin
      $display("unix_time_to_calendar_core verification clean");
    end else begin
      $display("unix_time_to_calendar_core verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_dates.size());
    $display("unix_time_to_calendar_core verification failed");
    $finish;
  end

endmodule
